// ===== rtl/dth_pkg.sv =====
// Package with the shared types and constants of the deadline timer heap.
package dth_pkg;

  localparam int TIMERS_DEF = 32;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_DEL = 2'd1;
  localparam logic [1:0] FUNC_SVC = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INACT   = 2'd2;
  localparam logic [1:0] ST_EXPIRED = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [47:0] deadline;
    logic [4:0]  timer_id;
    logic [15:0] user_tag;
    logic [47:0] now;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         slot;
    logic [15:0]        tag_out;
    logic signed [31:0] time_left;
    logic               last;
  } res_t;

endpackage

// ===== rtl/dth_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module dth_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/deadline_timer_heap_unit.sv =====
// Deadline timer heap: a pool of TIMERS timer slots kept as a binary min-heap on
// 48-bit deadline. A command beat is taken when start is high and busy is low, and
// busy then stays high until the command has finished. Add and delete give one
// result beat. Service gives one beat per expired timer, in heap order, and then
// a final beat with the time left to the earliest remaining deadline (-1 when the
// heap is empty). Every result beat is shown for exactly one cycle with done high
// and cannot be held off, so the receiver must take each beat as it comes. The heap
// order, deadlines, tags and heap positions live in four small RAMs with a
// registered read; the entry being sifted is held in registers and written once,
// where it comes to rest.
module deadline_timer_heap_unit
  import dth_pkg::*;
#(
  parameter int TIMERS = TIMERS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  dth_pkg::cmd_t   cmd,
  output logic            busy,
  output logic            done,
  output dth_pkg::res_t   res
);
  localparam int AW = $clog2(TIMERS);
  localparam int CW = $clog2(TIMERS + 1);
  localparam int SW = 5;

  typedef enum logic [4:0] {
    S_IDLE, S_ADD, S_DEL, S_RM, S_RM_RD, S_MV_DL, S_MV_PD,
    S_UP, S_UP_PD, S_UP_CMP, S_DN, S_DN_L, S_DN_R, S_DN_RC, S_DN_CMP,
    S_PLACE, S_SVC, S_SVC_DL, S_SVC_CHK
  } state_t;

  state_t            state;
  dth_pkg::cmd_t     cmd_r;
  logic [TIMERS-1:0] active;
  logic [CW-1:0]     count;

  // The entry being sifted is cur, with deadline cur_dl, sitting at hole idx.
  // other is the neighbour under comparison, bidx its heap index.
  logic [AW-1:0] idx, bidx, cur, other, rslot, tgt;
  logic [47:0]   cur_dl, best_dl;
  logic          svc_mode;

  // Heap-order memory (heap index -> slot), and per-slot memories for deadline,
  // tag and heap position. Only written entries are ever read.
  logic          hp_we;
  logic [AW-1:0] hp_wa, hp_ra;
  logic [AW-1:0] hp_wd, hp_rd;
  logic          dl_we;
  logic [AW-1:0] dl_wa, dl_ra;
  logic [47:0]   dl_wd, dl_rd;
  logic          tg_we;
  logic [AW-1:0] tg_ra;
  logic [15:0]   tg_rd;
  logic          ps_we;
  logic [AW-1:0] ps_wa, ps_ra;
  logic [AW-1:0] ps_wd, ps_rd;

  dth_ram #(.WIDTH(AW), .DEPTH(TIMERS)) u_heap (
    .clk(clk), .we(hp_we), .waddr(hp_wa), .wdata(hp_wd), .raddr(hp_ra), .rdata(hp_rd));
  dth_ram #(.WIDTH(48), .DEPTH(TIMERS)) u_dl (
    .clk(clk), .we(dl_we), .waddr(dl_wa), .wdata(dl_wd), .raddr(dl_ra), .rdata(dl_rd));
  dth_ram #(.WIDTH(16), .DEPTH(TIMERS)) u_tag (
    .clk(clk), .we(tg_we), .waddr(dl_wa), .wdata(cmd_r.user_tag), .raddr(tg_ra),
    .rdata(tg_rd));
  dth_ram #(.WIDTH(AW), .DEPTH(TIMERS)) u_pos (
    .clk(clk), .we(ps_we), .waddr(ps_wa), .wdata(ps_wd), .raddr(ps_ra), .rdata(ps_rd));

  // Lowest free slot.
  logic [AW-1:0] free_slot;
  logic          free_ok;
  always_comb begin
    free_slot = '0;
    free_ok   = 1'b0;
    for (int s = TIMERS - 1; s >= 0; s--) begin
      if (!active[s]) begin
        free_slot = AW'(s);
        free_ok   = 1'b1;
      end
    end
  end

  logic          add_ok;
  assign add_ok = (32'(count) < 32'(TIMERS)) && free_ok;

  // Heap index arithmetic. The children are formed two bits wider so that they can
  // be compared against the entry count without wrapping.
  logic [AW-1:0] parent_idx, hole_parent, last_idx;
  logic [AW+1:0] lw, rw;
  logic          l_in, r_in;
  assign parent_idx  = (idx - AW'(1)) >> 1;
  assign hole_parent = (ps_rd - AW'(1)) >> 1;
  assign last_idx    = AW'(count - CW'(1));
  assign lw          = {1'b0, idx, 1'b1};
  assign rw          = lw + (AW+2)'(1);
  assign l_in        = 32'(lw) < 32'(count);
  assign r_in        = 32'(rw) < 32'(count);

  // Sift-up moves on a strictly larger parent; sift-down moves on a strictly
  // smaller child, the left child winning a tie between the two children.
  logic up_move, dn_move;
  assign up_move = cur_dl < dl_rd;
  assign dn_move = best_dl < cur_dl;

  logic [47:0] diff;
  logic        due;
  assign diff = dl_rd - cmd_r.now;
  assign due  = dl_rd <= cmd_r.now;

  logic id_ok;
  assign id_ok = (32'(cmd_r.timer_id) < 32'(TIMERS)) && active[cmd_r.timer_id[AW-1:0]];

  assign busy = (state != S_IDLE);

  // Memory control is combinational on state. A move writes the neighbour into
  // the hole and records its new position; a placement does the same for cur.
  always_comb begin
    hp_we = 1'b0; hp_wa = idx; hp_wd = cur; hp_ra = '0;
    dl_we = 1'b0; dl_wa = free_slot; dl_wd = cmd_r.deadline; dl_ra = hp_rd;
    tg_we = 1'b0; tg_ra = hp_rd;
    ps_we = 1'b0; ps_wa = cur; ps_wd = idx; ps_ra = tgt;
    case (state)
      S_ADD: begin
        dl_we = add_ok; tg_we = add_ok;
      end
      S_UP:     hp_ra = parent_idx;
      S_DN:     hp_ra = lw[AW-1:0];
      S_DN_L:   hp_ra = rw[AW-1:0];
      S_RM:     hp_ra = last_idx;
      S_RM_RD:  hp_ra = hole_parent;
      S_SVC:    hp_ra = '0;
      S_UP_CMP, S_MV_PD: begin
        if (up_move) begin
          hp_we = 1'b1; hp_wd = other;
          ps_we = 1'b1; ps_wa = other;
        end
      end
      S_DN_CMP: begin
        if (dn_move) begin
          hp_we = 1'b1; hp_wd = other;
          ps_we = 1'b1; ps_wa = other;
        end
      end
      S_PLACE: begin
        hp_we = 1'b1; ps_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      active   <= '0;
      count    <= '0;
      done     <= 1'b0;
      svc_mode <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r    <= cmd;
            svc_mode <= (cmd.func == FUNC_SVC);
            case (cmd.func)
              FUNC_ADD: state <= S_ADD;
              FUNC_DEL: state <= S_DEL;
              FUNC_SVC: state <= S_SVC;
              default:  state <= S_IDLE;
            endcase
          end
        end
        S_ADD: begin
          if (add_ok) begin
            active[free_slot] <= 1'b1;
            count  <= count + CW'(1);
            idx    <= AW'(count);
            cur    <= free_slot;
            cur_dl <= cmd_r.deadline;
            res    <= '{status: ST_OK, slot: SW'(free_slot), tag_out: '0, time_left: '0,
                        last: 1'b1};
            state  <= S_UP;
          end else begin
            res   <= '{status: ST_FULL, slot: '0, tag_out: '0, time_left: '0, last: 1'b1};
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_DEL: begin
          if (id_ok) begin
            tgt   <= cmd_r.timer_id[AW-1:0];
            res   <= '{status: ST_OK, slot: cmd_r.timer_id, tag_out: '0, time_left: '0,
                       last: 1'b1};
            state <= S_RM;
          end else begin
            res   <= '{status: ST_INACT, slot: cmd_r.timer_id, tag_out: '0, time_left: '0,
                       last: 1'b1};
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        // Removal: the position of the slot and the last heap entry are read here.
        S_RM: begin
          active[tgt] <= 1'b0;
          count <= count - CW'(1);
          state <= S_RM_RD;
        end
        S_RM_RD: begin
          if (32'(ps_rd) == 32'(count)) begin
            // The removed entry was the last one, so nothing has to move.
            if (svc_mode) begin
              state <= S_SVC;
            end else begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            idx   <= ps_rd;
            cur   <= hp_rd;
            state <= S_MV_DL;
          end
        end
        S_MV_DL: begin
          cur_dl <= dl_rd;
          other  <= hp_rd;
          state  <= (idx == '0) ? S_DN : S_MV_PD;
        end
        S_MV_PD: begin
          if (up_move) begin
            idx   <= parent_idx;
            state <= S_UP;
          end else begin
            state <= S_DN;
          end
        end
        S_UP: begin
          state <= (idx == '0) ? S_PLACE : S_UP_PD;
        end
        S_UP_PD: begin
          other <= hp_rd;
          state <= S_UP_CMP;
        end
        S_UP_CMP: begin
          if (up_move) begin
            idx   <= parent_idx;
            state <= S_UP;
          end else begin
            state <= S_PLACE;
          end
        end
        S_DN: begin
          state <= l_in ? S_DN_L : S_PLACE;
        end
        S_DN_L: begin
          other <= hp_rd;
          bidx  <= lw[AW-1:0];
          state <= S_DN_R;
        end
        S_DN_R: begin
          best_dl <= dl_rd;
          rslot   <= hp_rd;
          state   <= r_in ? S_DN_RC : S_DN_CMP;
        end
        S_DN_RC: begin
          if (dl_rd < best_dl) begin
            best_dl <= dl_rd;
            other   <= rslot;
            bidx    <= rw[AW-1:0];
          end
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (dn_move) begin
            idx   <= bidx;
            state <= S_DN;
          end else begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          if (svc_mode) begin
            state <= S_SVC;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SVC: begin
          if (count == '0) begin
            res   <= '{status: ST_OK, slot: '0, tag_out: '0, time_left: '1, last: 1'b1};
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_SVC_DL;
          end
        end
        S_SVC_DL: begin
          tgt   <= hp_rd;
          state <= S_SVC_CHK;
        end
        S_SVC_CHK: begin
          done <= 1'b1;
          if (due) begin
            res   <= '{status: ST_EXPIRED, slot: SW'(tgt), tag_out: tg_rd, time_left: '0,
                       last: 1'b0};
            state <= S_RM;
          end else begin
            // The time left saturates at the largest positive 32-bit value.
            res   <= '{status: ST_OK, slot: '0, tag_out: '0,
                       time_left: (diff[47:31] != '0) ? 32'sh7FFF_FFFF : {1'b0, diff[30:0]},
                       last: 1'b1};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
